@@ hdl/ipv4_text_scanner_unit_defines.svh @@
// Assertion macros shared by the checker of the IPv4 text scanner.
// No dependencies; taken in by `include.
`ifndef IPV4_TEXT_SCANNER_UNIT_DEFINES_SVH
`define IPV4_TEXT_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication under asynchronous active-low reset.
`define ITS_ASSERT_IMP(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("its: same-cycle check failed");

// Next-cycle implication under asynchronous active-low reset.
`define ITS_ASSERT_NXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("its: next-cycle check failed");

`endif

@@ hdl/its_pkg.sv @@
// Shared types and constants of the IPv4 text scanner.
// No dependencies; imported by every module of the block.
package its_pkg;

	localparam int N_CELLS      = 16;
	localparam int N_GRP        = N_CELLS / 4;
	localparam int OUT_SIZE     = 16;
	localparam int LINE_MAX_DEF = 1024;
	localparam int FQ_DEPTH     = 4;
	localparam int RQ_DEPTH     = 2;

	localparam logic [7:0] CH_ZERO  = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_DIG9  = 8'h39;

	// classified character, as queued between front and back
	typedef struct packed {
		logic       eol;
		logic       dig;
		logic       dot;
		logic [3:0] dval;
	} chr_t;

	// one line result
	typedef struct packed {
		logic        found;
		logic [31:0] octets;
		logic [9:0]  start;
		logic [3:0]  len;
	} res_t;

endpackage

@@ hdl/its_front.sv @@
// Front end: classifies incoming characters and queues them for the cell array.
// Depends on its_pkg (chr_t, FQ_DEPTH, character constants).
module its_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    text_char,
	output logic          full,
	output logic          out_valid,
	output its_pkg::chr_t out_chr,
	input  logic          out_pop
);
	import its_pkg::*;

	localparam int PW = $clog2(FQ_DEPTH);
	localparam int CW = $clog2(FQ_DEPTH + 1);

	chr_t          mem_q [FQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	chr_t          cls;
	logic [7:0]    diff;
	logic          wr_en;
	logic          rd_en;

	always_comb begin
		diff     = text_char - CH_DIG0;
		cls.eol  = (text_char == CH_ZERO);
		cls.dig  = (text_char >= CH_DIG0) && (text_char <= CH_DIG9);
		cls.dot  = (text_char == CH_DOT);
		cls.dval = diff[3:0];
	end

	assign full      = (cnt_q == CW'(FQ_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_chr   = mem_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = out_pop && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (wr_en && !rd_en) cnt_q <= cnt_q + CW'(1);
			else if (rd_en && !wr_en) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= cls;
	end

endmodule

@@ hdl/its_cells.sv @@
// Back end, first stage: array of candidate cells, one per address start in flight.
// Depends on its_pkg (chr_t, N_CELLS, OUT_SIZE).
module its_cells #(
	parameter int LINE_MAX = its_pkg::LINE_MAX_DEF,
	parameter int SW       = $clog2(LINE_MAX)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  its_pkg::chr_t        in_chr,
	output logic                 vld_s1,
	output logic                 eol_s1,
	output logic [its_pkg::N_CELLS-1:0] off_s1,
	output logic [SW-1:0]        start_s1 [its_pkg::N_CELLS],
	output logic [3:0]           len_s1   [its_pkg::N_CELLS],
	output logic [31:0]          oct_s1   [its_pkg::N_CELLS]
);
	import its_pkg::*;

	localparam logic [1:0] LAST_GRP = 2'd3;
	localparam logic [1:0] MAX_DIGS = 2'd3;

	logic [N_CELLS-1:0] live_q, live_n;
	logic [N_CELLS-1:0] nz_q, nz_n;
	logic [1:0]         grp_q  [N_CELLS];
	logic [1:0]         grp_n  [N_CELLS];
	logic [1:0]         digs_q [N_CELLS];
	logic [1:0]         digs_n [N_CELLS];
	logic [3:0]         len_q  [N_CELLS];
	logic [3:0]         len_n  [N_CELLS];
	logic [9:0]         val_q  [N_CELLS];
	logic [9:0]         val_n  [N_CELLS];
	logic [SW-1:0]      start_q [N_CELLS];
	logic [SW-1:0]      start_n [N_CELLS];
	logic [7:0]         oct_q  [N_CELLS][3];
	logic [7:0]         oct_n  [N_CELLS][3];
	logic [N_CELLS-1:0] off_c;
	logic [SW-1:0]      pos_q;
	logic               step;

	assign step = en && in_valid;

	always_comb begin
		logic taken;
		live_n  = live_q;
		nz_n    = nz_q;
		grp_n   = grp_q;
		digs_n  = digs_q;
		len_n   = len_q;
		val_n   = val_q;
		start_n = start_q;
		oct_n   = oct_q;
		off_c   = '0;
		taken   = 1'b0;
		for (int i = 0; i < N_CELLS; i++) begin
			if (in_valid && live_q[i]) begin
				if (in_chr.dig && digs_q[i] != MAX_DIGS) begin
					val_n[i]  = 10'((val_q[i] << 3) + (val_q[i] << 1) + 10'(in_chr.dval));
					digs_n[i] = digs_q[i] + 2'd1;
					len_n[i]  = len_q[i] + 4'd1;
				end else if (digs_q[i] == 2'd0 || val_q[i] > 10'd255) begin
					live_n[i] = 1'b0;
				end else if (grp_q[i] != LAST_GRP) begin
					if (!in_chr.dot) begin
						live_n[i] = 1'b0;
					end else begin
						nz_n[i]              = nz_q[i] || (val_q[i] != 10'd0);
						oct_n[i][grp_q[i]]   = val_q[i][7:0];
						grp_n[i]             = grp_q[i] + 2'd1;
						val_n[i]             = 10'd0;
						digs_n[i]            = 2'd0;
						len_n[i]             = len_q[i] + 4'd1;
					end
				end else begin
					// fourth group closed: offer unless a digit follows or all four groups are zero
					off_c[i]  = !in_chr.dig && (nz_q[i] || val_q[i] != 10'd0) &&
					            ({1'b0, len_q[i]} < 5'(OUT_SIZE));
					live_n[i] = 1'b0;
				end
			end
		end
		if (in_valid && in_chr.eol) begin
			live_n = '0;
		end else if (in_valid && in_chr.dig) begin
			// open a new start in the lowest free cell
			for (int i = 0; i < N_CELLS; i++) begin
				if (!taken && !live_n[i]) begin
					taken      = 1'b1;
					live_n[i]  = 1'b1;
					nz_n[i]    = 1'b0;
					grp_n[i]   = 2'd0;
					digs_n[i]  = 2'd1;
					len_n[i]   = 4'd1;
					val_n[i]   = 10'(in_chr.dval);
					start_n[i] = pos_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			pos_q  <= '0;
			vld_s1 <= 1'b0;
			off_s1 <= '0;
		end else if (en) begin
			vld_s1 <= in_valid;
			off_s1 <= off_c;
			if (in_valid) begin
				live_q <= live_n;
				if (in_chr.eol) pos_q <= '0;
				else if (pos_q != SW'(LINE_MAX - 1)) pos_q <= pos_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			nz_q    <= nz_n;
			grp_q   <= grp_n;
			digs_q  <= digs_n;
			len_q   <= len_n;
			val_q   <= val_n;
			start_q <= start_n;
			oct_q   <= oct_n;
		end
		if (en) begin
			eol_s1 <= in_chr.eol;
			for (int i = 0; i < N_CELLS; i++) begin
				start_s1[i] <= start_q[i];
				len_s1[i]   <= len_q[i];
				oct_s1[i]   <= {oct_q[i][0], oct_q[i][1], oct_q[i][2], val_q[i][7:0]};
			end
		end
	end

endmodule

@@ hdl/its_pick.sv @@
// Back end, later stages: registered min tree over offering cells and best-match register.
// Depends on its_pkg (res_t, N_CELLS, N_GRP).
module its_pick #(
	parameter int SW = $clog2(its_pkg::LINE_MAX_DEF)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rq_full,
	input  logic                 vld_s1,
	input  logic                 eol_s1,
	input  logic [its_pkg::N_CELLS-1:0] off_s1,
	input  logic [SW-1:0]        start_s1 [its_pkg::N_CELLS],
	input  logic [3:0]           len_s1   [its_pkg::N_CELLS],
	input  logic [31:0]          oct_s1   [its_pkg::N_CELLS],
	output logic                 en,
	output logic                 rq_push,
	output its_pkg::res_t        rq_din
);
	import its_pkg::*;

	localparam int SWX = (SW > 10) ? SW : 10;

	typedef struct packed {
		logic          v;
		logic [SW-1:0] start;
		logic [3:0]    len;
		logic [31:0]   oct;
	} cand_t;

	// earlier start wins; on a tie the lower cell wins
	function automatic cand_t pick2(input cand_t a, input cand_t b);
		return (a.v && (!b.v || a.start <= b.start)) ? a : b;
	endfunction

	cand_t             cand   [N_CELLS];
	cand_t             grp_c  [N_GRP];
	cand_t             grp_s2 [N_GRP];
	cand_t             win_c;
	cand_t             win_s3;
	logic              vld_s2, eol_s2;
	logic              vld_s3, eol_s3;
	logic              best_found_q;
	logic [SW-1:0]     best_start_q;
	logic [3:0]        best_len_q;
	logic [31:0]       best_oct_q;
	logic              take;
	logic              nf;
	logic [SW-1:0]     ns;
	logic [SWX-1:0]    ns_x;

	always_comb begin
		for (int i = 0; i < N_CELLS; i++) begin
			cand[i].v     = off_s1[i];
			cand[i].start = start_s1[i];
			cand[i].len   = len_s1[i];
			cand[i].oct   = oct_s1[i];
		end
		for (int g = 0; g < N_GRP; g++)
			grp_c[g] = pick2(pick2(cand[4*g], cand[4*g+1]), pick2(cand[4*g+2], cand[4*g+3]));
		win_c = pick2(pick2(grp_s2[0], grp_s2[1]), pick2(grp_s2[2], grp_s2[3]));
	end

	// hold the whole back end only when a line result cannot enter the queue
	assign en      = !(vld_s3 && eol_s3 && rq_full);
	assign take    = vld_s3 && win_s3.v && (!best_found_q || win_s3.start < best_start_q);
	assign rq_push = en && vld_s3 && eol_s3;
	assign nf      = take || best_found_q;
	assign ns      = take ? win_s3.start : best_start_q;
	assign ns_x    = SWX'(ns);

	always_comb begin
		rq_din.found  = nf;
		rq_din.octets = nf ? (take ? win_s3.oct : best_oct_q) : 32'd0;
		rq_din.start  = nf ? ns_x[9:0] : 10'd0;
		rq_din.len    = nf ? (take ? win_s3.len : best_len_q) : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			best_found_q <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (vld_s3 && eol_s3) best_found_q <= 1'b0;
			else if (take) best_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eol_s2 <= eol_s1;
			eol_s3 <= eol_s2;
			grp_s2 <= grp_c;
			win_s3 <= win_c;
			if (take) begin
				best_start_q <= win_s3.start;
				best_len_q   <= win_s3.len;
				best_oct_q   <= win_s3.oct;
			end
		end
	end

endmodule

@@ hdl/its_rq.sv @@
// Result queue: holds finished line results until the consumer pops them.
// Depends on its_pkg (res_t, RQ_DEPTH).
module its_rq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  its_pkg::res_t din,
	output logic          full,
	output logic          empty,
	input  logic          rd,
	output its_pkg::res_t dout
);
	import its_pkg::*;

	localparam int PW = $clog2(RQ_DEPTH);
	localparam int CW = $clog2(RQ_DEPTH + 1);

	res_t          mem_q [RQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          wr_en;
	logic          rd_en;

	assign full  = (cnt_q == CW'(RQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];
	assign wr_en = wr && !full;
	assign rd_en = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (wr_en && !rd_en) cnt_q <= cnt_q + CW'(1);
			else if (rd_en && !wr_en) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= din;
	end

endmodule

@@ hdl/ipv4_text_scanner_unit.sv @@
// Channel   Handshake      Payload
// text in   push / full    text_char[7:0]
// result    pop / empty    found, octet_first..octet_fourth, match_start[9:0],
//                          match_length[3:0]
//
// One character is taken every cycle while the front queue has room; the cell array
// updates all 16 starts at once. A line result passes from its zero byte through
// the front queue, the cell stage, two min-tree stages and the result queue.
// Reset clears all cells, the position count and the best match; the queues empty.
// The back end holds only when a line result meets a full result queue;
// the front queue keeps taking characters until it fills.
// Top level of the IPv4 text scanner; depends on its_pkg, its_front, its_cells,
// its_pick and its_rq.
module ipv4_text_scanner_unit #(
	parameter int LINE_MAX = its_pkg::LINE_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_char,
	output logic       empty,
	input  logic       pop,
	output logic       found,
	output logic [7:0] octet_first,
	output logic [7:0] octet_second,
	output logic [7:0] octet_third,
	output logic [7:0] octet_fourth,
	output logic [9:0] match_start,
	output logic [3:0] match_length
);
	import its_pkg::*;

	localparam int SW = $clog2(LINE_MAX);

	chr_t               fq_chr;
	logic               fq_valid;
	logic               en;
	logic               vld_s1;
	logic               eol_s1;
	logic [N_CELLS-1:0] off_s1;
	logic [SW-1:0]      start_s1 [N_CELLS];
	logic [3:0]         len_s1   [N_CELLS];
	logic [31:0]        oct_s1   [N_CELLS];
	logic               rq_push;
	logic               rq_full;
	res_t               rq_din;
	res_t               rq_dout;

	its_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.text_char (text_char),
		.full      (full),
		.out_valid (fq_valid),
		.out_chr   (fq_chr),
		.out_pop   (en)
	);

	its_cells #(
		.LINE_MAX (LINE_MAX),
		.SW       (SW)
	) u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fq_valid),
		.in_chr   (fq_chr),
		.vld_s1   (vld_s1),
		.eol_s1   (eol_s1),
		.off_s1   (off_s1),
		.start_s1 (start_s1),
		.len_s1   (len_s1),
		.oct_s1   (oct_s1)
	);

	its_pick #(
		.SW (SW)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.rq_full  (rq_full),
		.vld_s1   (vld_s1),
		.eol_s1   (eol_s1),
		.off_s1   (off_s1),
		.start_s1 (start_s1),
		.len_s1   (len_s1),
		.oct_s1   (oct_s1),
		.en       (en),
		.rq_push  (rq_push),
		.rq_din   (rq_din)
	);

	its_rq u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rq_push),
		.din    (rq_din),
		.full   (rq_full),
		.empty  (empty),
		.rd     (pop),
		.dout   (rq_dout)
	);

	assign found        = rq_dout.found;
	assign octet_first  = rq_dout.octets[31:24];
	assign octet_second = rq_dout.octets[23:16];
	assign octet_third  = rq_dout.octets[15:8];
	assign octet_fourth = rq_dout.octets[7:0];
	assign match_start  = rq_dout.start;
	assign match_length = rq_dout.len;

endmodule

@@ hdl/its_checker.sv @@
// Port-level checks for the IPv4 text scanner, bound to its top level.
// Depends on ipv4_text_scanner_unit_defines.svh for the assertion macros.
`include "ipv4_text_scanner_unit_defines.svh"

module its_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic [7:0] text_char,
	input logic       empty,
	input logic       pop,
	input logic       found,
	input logic [7:0] octet_first,
	input logic [7:0] octet_second,
	input logic [7:0] octet_third,
	input logic [7:0] octet_fourth,
	input logic [9:0] match_start,
	input logic [3:0] match_length
);

	// a miss carries an all-zero payload
	`ITS_ASSERT_IMP(a_miss_zero, clk, arst_n, !empty && !found, octet_first == 8'd0 && octet_second == 8'd0 && octet_third == 8'd0 && octet_fourth == 8'd0 && match_start == 10'd0 && match_length == 4'd0)

	// a hit spans at least seven characters and is not all zero groups
	`ITS_ASSERT_IMP(a_hit_shape, clk, arst_n, !empty && found, match_length >= 4'd7 && (octet_first != 8'd0 || octet_second != 8'd0 || octet_third != 8'd0 || octet_fourth != 8'd0))

	// a waiting result holds until transferred
	`ITS_ASSERT_NXT(a_res_hold, clk, arst_n, !empty && !pop, !empty && $stable(found) && $stable(match_start) && $stable(match_length) && $stable(octet_first))

endmodule

bind ipv4_text_scanner_unit its_checker u_its_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench for ipv4_text_scanner_unit: drives lines of text and checks every line result
// against a cycle-free predictor of the scanner. Depends on its_pkg and the RTL only.
module tb;
	import its_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LINE_LIMIT     = LINE_MAX_DEF;

	// one start position being followed through the text
	typedef struct packed {
		logic        live;
		logic        nz;
		logic [1:0]  grp;
		logic [1:0]  digs;
		logic [3:0]  len;
		logic [9:0]  val;
		logic [9:0]  start;
		logic [23:0] oct;
	} addr_track_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] text_char = CH_ZERO;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic       found;
	logic [7:0] octet_first;
	logic [7:0] octet_second;
	logic [7:0] octet_third;
	logic [7:0] octet_fourth;
	logic [9:0] match_start;
	logic [3:0] match_length;

	addr_track_t addr_tracks [N_CELLS];
	int unsigned char_pos;
	logic        best_hit;
	logic [31:0] best_octets;
	logic [9:0]  best_at;
	logic [3:0]  best_len;

	res_t       pending_scans [$];
	logic [7:0] line_text [$];

	int send_idle;
	int pop_stall;
	int chars_sent;
	int lines_seen;
	int hits_seen;
	int fail_count;
	int stuck_cycles;

	ipv4_text_scanner_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.text_char    (text_char),
		.empty        (empty),
		.pop          (pop),
		.found        (found),
		.octet_first  (octet_first),
		.octet_second (octet_second),
		.octet_third  (octet_third),
		.octet_fourth (octet_fourth),
		.match_start  (match_start),
		.match_length (match_length)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic is_digit_char(input logic [7:0] c);
		return (c >= CH_DIG0) && (c <= CH_DIG9);
	endfunction

	task automatic clear_scan();
		for (int i = 0; i < N_CELLS; i++)
			addr_tracks[i] = '0;
		char_pos = 0;
		best_hit = 1'b0;
		best_octets = '0;
		best_at = '0;
		best_len = '0;
	endtask

	task automatic offer_track(input addr_track_t t);
		if ((t.nz || t.val != 0) && t.len < OUT_SIZE && !(best_hit && t.start >= best_at)) begin
			best_hit = 1'b1;
			best_at = t.start;
			best_len = t.len;
			best_octets = {t.oct, t.val[7:0]};
		end
	endtask

	task automatic step_track(input int i, input logic [7:0] c);
		addr_track_t t;
		t = addr_tracks[i];
		if (is_digit_char(c) && t.digs < 3) begin
			t.val = 10'(t.val * 10 + (c - CH_DIG0));
			t.digs = t.digs + 2'd1;
			t.len = t.len + 4'd1;
		end else if (t.digs == 0 || t.val > 255) begin
			t.live = 1'b0;
		end else if (t.grp < 3) begin
			if (c != CH_DOT) begin
				t.live = 1'b0;
			end else begin
				if (t.val != 0)
					t.nz = 1'b1;
				case (t.grp)
					2'd0: t.oct[23:16] = t.val[7:0];
					2'd1: t.oct[15:8] = t.val[7:0];
					default: t.oct[7:0] = t.val[7:0];
				endcase
				t.grp = t.grp + 2'd1;
				t.val = '0;
				t.digs = '0;
				t.len = t.len + 4'd1;
			end
		end else begin
			// fourth group closed: a digit right after it voids the match
			if (!is_digit_char(c))
				offer_track(t);
			t.live = 1'b0;
		end
		addr_tracks[i] = t;
	endtask

	task automatic scan_char(input logic [7:0] c);
		addr_track_t fresh;
		res_t line_res;
		bit placed;
		for (int i = 0; i < N_CELLS; i++)
			if (addr_tracks[i].live)
				step_track(i, c);
		if (c != CH_ZERO) begin
			placed = 1'b0;
			if (is_digit_char(c)) begin
				for (int i = 0; i < N_CELLS && !placed; i++) begin
					if (!addr_tracks[i].live) begin
						fresh = '0;
						fresh.live = 1'b1;
						fresh.start = char_pos[9:0];
						addr_tracks[i] = fresh;
						step_track(i, c);
						placed = 1'b1;
					end
				end
			end
			// hold the position at the last index of a long line
			if (char_pos < LINE_LIMIT - 1)
				char_pos++;
		end else begin
			line_res.found = best_hit;
			line_res.octets = best_octets;
			line_res.start = best_at;
			line_res.len = best_len;
			pending_scans.push_back(line_res);
			clear_scan();
		end
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	task automatic check_result();
		res_t want;
		string got;
		got = $sformatf("found=%0d %0d.%0d.%0d.%0d start=%0d len=%0d", found, octet_first,
			octet_second, octet_third, octet_fourth, match_start, match_length);
		if (pending_scans.size() == 0) begin
			note_failure({"result with no line pending: ", got});
		end else begin
			want = pending_scans.pop_front();
			lines_seen++;
			if (want.found)
				hits_seen++;
			if (found !== want.found || octet_first !== want.octets[31:24] ||
					octet_second !== want.octets[23:16] || octet_third !== want.octets[15:8] ||
					octet_fourth !== want.octets[7:0] || match_start !== want.start ||
					match_length !== want.len)
				note_failure($sformatf(
					"line %0d: expected found=%0d %0d.%0d.%0d.%0d start=%0d len=%0d, got %s",
					lines_seen, want.found, want.octets[31:24], want.octets[23:16],
					want.octets[15:8], want.octets[7:0], want.start, want.len, got));
		end
	endtask

	always @(posedge clk) begin : transfer_monitor
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (pop && !empty) begin
				check_result();
				moved = 1'b1;
			end
			if (push && !full) begin
				scan_char(text_char);
				chars_sent++;
				moved = 1'b1;
			end
			stuck_cycles = moved ? 0 : stuck_cycles + 1;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	always @(negedge clk)
		pop <= ($urandom_range(0, 99) >= pop_stall);

	task automatic send_char(input logic [7:0] c);
		while (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		text_char <= c;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_text[k])
			send_char(line_text[k]);
		send_char(CH_ZERO);
		line_text.delete();
	endtask

	// drop push and hold until every line result is back
	task automatic wait_drained();
		push <= 1'b0;
		@(negedge clk);
		while (pending_scans.size() != 0)
			@(negedge clk);
	endtask

	task automatic add_text(input string s);
		for (int k = 0; k < s.len(); k++)
			line_text.push_back(s[k]);
	endtask

	function automatic logic [7:0] any_char();
		case ($urandom_range(0, 7))
			0, 1, 2: return 8'(CH_DIG0 + $urandom_range(0, 9));
			3, 4: return CH_DOT;
			5: return 8'(8'h61 + $urandom_range(0, 25));
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic add_number(input int v);
		if (v >= 100)
			line_text.push_back(8'(CH_DIG0 + v / 100));
		if (v >= 10)
			line_text.push_back(8'(CH_DIG0 + (v / 10) % 10));
		line_text.push_back(8'(CH_DIG0 + v % 10));
	endtask

	task automatic add_group();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			add_number(0);
		else if (r < 70)
			add_number($urandom_range(0, 255));
		else if (r < 85)
			repeat ($urandom_range(1, 3)) line_text.push_back(8'(CH_DIG0 + $urandom_range(0, 9)));
		else if (r < 95)
			add_number($urandom_range(256, 999));
		else
			repeat (4) line_text.push_back(8'(CH_DIG0 + $urandom_range(0, 9)));
	endtask

	task automatic add_address();
		int groups;
		groups = ($urandom_range(0, 9) == 0) ? 3 : 4;
		for (int g = 0; g < groups; g++) begin
			add_group();
			if (g < groups - 1)
				line_text.push_back(($urandom_range(0, 11) == 0) ? any_char() : CH_DOT);
		end
	endtask

	task automatic build_random_line();
		repeat ($urandom_range(0, 3)) line_text.push_back(any_char());
		if ($urandom_range(0, 4) != 0)
			add_address();
		else
			repeat ($urandom_range(0, 10)) line_text.push_back(any_char());
		if ($urandom_range(0, 4) == 0) begin
			line_text.push_back(any_char());
			add_address();
		end
		repeat ($urandom_range(0, 3)) line_text.push_back(any_char());
	endtask

	// empty line, all-zero address, byte extremes, overlapping start past a 256 group
	task automatic test_boundary_lines();
		send_idle = 0;
		pop_stall = 0;
		send_line();
		line_text.push_back(8'hFF);
		add_text("0.0.0.0");
		send_line();
		add_text("1256.255.0.9");
		send_line();
		wait_drained();
	endtask

	// address placed after the position count has saturated; overlapping starts share it
	task automatic test_saturated_position();
		logic [7:0] c;
		send_idle = 15;
		pop_stall = 15;
		repeat (LINE_LIMIT + 6) begin
			do c = 8'($urandom_range(1, 255)); while (is_digit_char(c));
			line_text.push_back(c);
		end
		add_text("1.2.3.45.6.7");
		send_line();
		wait_drained();
	endtask

	task automatic test_random_lines(input int idle, input int stall, input int budget);
		int first;
		send_idle = idle;
		pop_stall = stall;
		first = chars_sent;
		while (chars_sent - first < budget) begin
			build_random_line();
			send_line();
		end
		wait_drained();
	endtask

	initial begin
		clear_scan();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_boundary_lines();
		test_saturated_position();
		test_random_lines(0, 0, 150);
		test_random_lines(67, 0, 150);
		test_random_lines(0, 67, 150);
		test_random_lines(15, 15, 150);
		repeat (12) @(negedge clk);
		$display("scanned %0d characters in %0d lines, %0d lines held an address",
			chars_sent, lines_seen, hits_seen);
		$display("covered empty and all-zero lines, octet bounds, a saturated position, four pacing mixes");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
